// ===== hw/rtl/rtcat_pkg.sv =====
// Shared types, constants and small functions for the RTC alarm time adder.
// No dependencies; imported by every module of the block but rtcat_cdiv.
package rtcat_pkg;

    localparam int unsigned ERA_DAYS = 146097;

    localparam logic [4:0] MONTH_JAN = 5'd1;
    localparam logic [4:0] MONTH_FEB = 5'd2;
    localparam logic [4:0] MONTH_DEC = 5'd12;

    // first day of each month within a year that starts on March 1
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    function automatic int days_w(input int ib);
        int qw1;
        int w2;
        int qw2;
        int w3;
        qw1 = ib - 4;
        w2  = ((qw1 > 7) ? qw1 : 7) + 1;
        qw2 = w2 - 5;
        w3  = ((qw2 > 6) ? qw2 : 6) + 1;
        return w3 - 4;
    endfunction

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        return {4'b0, b[7:4]} * 8'd10 + {4'b0, b[3:0]};
    endfunction

    function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] rest;
        priority if (v >= 6'd60) begin
            tens = 4'd6;
            rest = v - 6'd60;
        end else if (v >= 6'd50) begin
            tens = 4'd5;
            rest = v - 6'd50;
        end else if (v >= 6'd40) begin
            tens = 4'd4;
            rest = v - 6'd40;
        end else if (v >= 6'd30) begin
            tens = 4'd3;
            rest = v - 6'd30;
        end else if (v >= 6'd20) begin
            tens = 4'd2;
            rest = v - 6'd20;
        end else if (v >= 6'd10) begin
            tens = 4'd1;
            rest = v - 6'd10;
        end else begin
            tens = 4'd0;
            rest = v;
        end
        return {tens, rest[3:0]};
    endfunction

    function automatic logic [4:0] month_days(input logic [4:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: len = 5'd31;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    // yoe/4 - yoe/100 for a year of era below 400
    function automatic logic [6:0] year_adj(input logic [8:0] yoe);
        logic [1:0] cent;
        priority if (yoe >= 9'd300) begin
            cent = 2'd3;
        end else if (yoe >= 9'd200) begin
            cent = 2'd2;
        end else if (yoe >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        return 7'(yoe >> 2) - 7'(cent);
    endfunction

endpackage

// ===== hw/rtl/rtcat_cdiv.sv =====
// Divide by a constant: multiply by a rounded-up reciprocal and shift.
// Exact for every input of XW bits. No dependencies.
module rtcat_cdiv #(
    parameter int XW  = 18,
    parameter int QW  = 8,
    parameter int DIV = 3
) (
    input  logic [XW-1:0] i_x,
    output logic [QW-1:0] o_q
);
    localparam int SH = XW + $clog2(DIV);
    localparam int MW = XW + 1;
    localparam int PW = XW + MW;
    localparam longint unsigned MAG =
        ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [PW-1:0] prod;

    assign prod = PW'(i_x) * PW'(MW'(MAG));
    assign o_q  = QW'(prod >> SH);

endmodule

// ===== hw/rtl/rtcat_time.sv =====
// Time-of-day carry pipeline: seconds plus interval split into days, hours,
// minutes and seconds over six stages. Uses rtcat_pkg and rtcat_cdiv.
module rtcat_time #(
    parameter int INTERVAL_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [INTERVAL_BITS:0] i_t1,
    input  logic [6:0]           i_minute,
    input  logic [5:0]           i_hour,
    output logic                 o_valid,
    output logic [rtcat_pkg::days_w(INTERVAL_BITS)-1:0] o_days,
    output rtcat_pkg::t_hms      o_hms
);
    import rtcat_pkg::*;

    localparam int T1_W = INTERVAL_BITS + 1;
    localparam int QW1  = INTERVAL_BITS - 4;
    localparam int W2   = ((QW1 > 7) ? QW1 : 7) + 1;
    localparam int QW2  = W2 - 5;
    localparam int W3   = ((QW2 > 6) ? QW2 : 6) + 1;
    localparam int QW3  = days_w(INTERVAL_BITS);

    logic [5:0]     r_vld;

    logic [QW1-1:0] n_q1;
    logic [QW1-1:0] r_a_q1;
    logic [5:0]     r_a_t1lo;
    logic [6:0]     r_a_min;
    logic [5:0]     r_a_hour;

    logic [5:0]     n_sec;
    logic [W2-1:0]  n_t2;
    logic [5:0]     r_b_sec;
    logic [W2-1:0]  r_b_t2;
    logic [5:0]     r_b_hour;

    logic [QW2-1:0] n_q2;
    logic [QW2-1:0] r_c_q2;
    logic [5:0]     r_c_t2lo;
    logic [5:0]     r_c_sec;
    logic [5:0]     r_c_hour;

    logic [5:0]     n_min;
    logic [W3-1:0]  n_t3;
    logic [5:0]     r_d_min;
    logic [W3-1:0]  r_d_t3;
    logic [5:0]     r_d_sec;

    logic [QW3-1:0] n_q3;
    logic [QW3-1:0] r_e_q3;
    logic [4:0]     r_e_t3lo;
    logic [5:0]     r_e_min;
    logic [5:0]     r_e_sec;

    logic [4:0]     n_hour;
    logic [QW3-1:0] r_f_days;
    t_hms           r_f_hms;

    // t / 60 as (t >> 2) / 15
    rtcat_cdiv #(.XW(T1_W - 2), .QW(QW1), .DIV(15)) u_div_sec (
        .i_x (i_t1[T1_W-1:2]),
        .o_q (n_q1)
    );

    rtcat_cdiv #(.XW(W2 - 2), .QW(QW2), .DIV(15)) u_div_min (
        .i_x (r_b_t2[W2-1:2]),
        .o_q (n_q2)
    );

    // t / 24 as (t >> 3) / 3
    rtcat_cdiv #(.XW(W3 - 3), .QW(QW3), .DIV(3)) u_div_hour (
        .i_x (r_d_t3[W3-1:3]),
        .o_q (n_q3)
    );

    // remainders fit in the low bits, so only those are subtracted
    always_comb begin
        n_sec  = 6'(r_a_t1lo - 6'(6'(r_a_q1) * 6'd60));
        n_t2   = W2'(r_a_min) + W2'(r_a_q1);
        n_min  = 6'(r_c_t2lo - 6'(6'(r_c_q2) * 6'd60));
        n_t3   = W3'(r_c_hour) + W3'(r_c_q2);
        n_hour = 5'(r_e_t3lo - 5'(5'(r_e_q3) * 5'd24));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_q1   <= n_q1;
        r_a_t1lo <= i_t1[5:0];
        r_a_min  <= i_minute;
        r_a_hour <= i_hour;

        r_b_sec  <= n_sec;
        r_b_t2   <= n_t2;
        r_b_hour <= r_a_hour;

        r_c_q2   <= n_q2;
        r_c_t2lo <= r_b_t2[5:0];
        r_c_sec  <= r_b_sec;
        r_c_hour <= r_b_hour;

        r_d_min  <= n_min;
        r_d_t3   <= n_t3;
        r_d_sec  <= r_c_sec;

        r_e_q3   <= n_q3;
        r_e_t3lo <= r_d_t3[4:0];
        r_e_min  <= r_d_min;
        r_e_sec  <= r_d_sec;

        r_f_days        <= r_e_q3;
        r_f_hms.hour    <= n_hour;
        r_f_hms.minute  <= r_e_min;
        r_f_hms.second  <= r_e_sec;
    end

    assign o_valid = r_vld[5];
    assign o_days  = r_f_days;
    assign o_hms   = r_f_hms;

endmodule

// ===== hw/rtl/rtcat_cal.sv =====
// Calendar setup pipeline: month length of the current month and the day of
// the 400-year era of the first of the following month. Uses rtcat_pkg, rtcat_cdiv.
module rtcat_cal (
    input  logic        i_clk,
    input  logic [7:0]  i_century,
    input  logic [7:0]  i_year,
    input  logic [4:0]  i_month,
    input  logic [5:0]  i_day,
    output logic [4:0]  o_dim,
    output logic [17:0] o_doe,
    output logic [5:0]  o_day
);
    import rtcat_pkg::*;

    logic [14:0] r_a_year;
    logic [4:0]  r_a_month;
    logic [5:0]  r_a_day;

    logic [5:0]  n_yq;
    logic [5:0]  r_b_yq;
    logic [14:0] r_b_year;
    logic [4:0]  r_b_month;
    logic [5:0]  r_b_day;

    logic [8:0]  n_cyc;
    logic [8:0]  r_c_cyc;
    logic [4:0]  r_c_month;
    logic [5:0]  r_c_day;

    logic        n_leap;
    logic [3:0]  n_m2;
    logic [3:0]  n_mp;
    logic [8:0]  n_yoe;
    logic [4:0]  r_d_dim;
    logic [8:0]  r_d_yoe;
    logic [8:0]  r_d_doy;
    logic [5:0]  r_d_day;

    logic [17:0] r_e_y365;
    logic [6:0]  r_e_adj;
    logic [8:0]  r_e_doy;
    logic [4:0]  r_e_dim;
    logic [5:0]  r_e_day;

    logic [17:0] r_f_doe;
    logic [4:0]  r_f_dim;
    logic [5:0]  r_f_day;

    rtcat_cdiv #(.XW(15), .QW(6), .DIV(400)) u_div_era (
        .i_x (r_a_year),
        .o_q (n_yq)
    );

    always_comb begin
        n_cyc  = 9'(r_b_year - 15'(15'(r_b_yq) * 15'd400));
        n_leap = (r_c_cyc[1:0] == 2'd0) && (r_c_cyc != 9'd100) &&
                 (r_c_cyc != 9'd200) && (r_c_cyc != 9'd300);
        // month after the current one; December and beyond roll to January
        n_m2   = (r_c_month >= MONTH_DEC) ? 4'd1 : 4'(r_c_month + 5'd1);
        n_mp   = (n_m2 > 4'd2) ? (n_m2 - 4'd3) : (n_m2 + 4'd9);
        // Jan/Feb belong to the previous March-based year; the year bump
        // of a December rollover cancels against that
        if ((r_c_month == 5'd0) || (r_c_month == MONTH_JAN)) begin
            n_yoe = (r_c_cyc == 9'd0) ? 9'd399 : (r_c_cyc - 9'd1);
        end else begin
            n_yoe = r_c_cyc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_year  <= {7'b0, i_century} * 15'd100 + 15'(i_year);
        r_a_month <= i_month;
        r_a_day   <= i_day;

        r_b_yq    <= n_yq;
        r_b_year  <= r_a_year;
        r_b_month <= r_a_month;
        r_b_day   <= r_a_day;

        r_c_cyc   <= n_cyc;
        r_c_month <= r_b_month;
        r_c_day   <= r_b_day;

        r_d_dim   <= month_days(r_c_month, n_leap);
        r_d_yoe   <= n_yoe;
        r_d_doy   <= MONTH_START[n_mp];
        r_d_day   <= r_c_day;

        r_e_y365  <= 18'(r_d_yoe) * 18'd365;
        r_e_adj   <= year_adj(r_d_yoe);
        r_e_doy   <= r_d_doy;
        r_e_dim   <= r_d_dim;
        r_e_day   <= r_d_day;

        r_f_doe   <= r_e_y365 + 18'(r_e_adj) + 18'(r_e_doy);
        r_f_dim   <= r_e_dim;
        r_f_day   <= r_e_day;
    end

    assign o_dim = r_f_dim;
    assign o_doe = r_f_doe;
    assign o_day = r_f_day;

endmodule

// ===== hw/rtl/rtcat_dom.sv =====
// Day-of-month pipeline: adds whole days, wraps through months and years via
// the 400-year era, encodes the result word in BCD. Uses rtcat_pkg, rtcat_cdiv.
module rtcat_dom #(
    parameter int DAYS_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DAYS_W-1:0] i_days,
    input  logic [5:0]        i_day,
    input  logic [4:0]        i_dim,
    input  logic [17:0]       i_doe,
    input  rtcat_pkg::t_hms   i_hms,
    output logic              o_valid,
    output logic [5:0]        o_day_bcd,
    output logic [5:0]        o_hour_bcd,
    output logic [6:0]        o_minute_bcd,
    output logic [6:0]        o_second_bcd
);
    import rtcat_pkg::*;

    localparam int DT_W = ((DAYS_W > 6) ? DAYS_W : 6) + 1;
    localparam int NW   = ((DT_W > 18) ? DT_W : 18) + 1;

    logic [9:0]      r_vld;
    t_hms            r_hms [9];
    logic [5:0]      r_keep [7];   // {no wrap, day}, stages 2..8

    logic [DT_W-1:0] r1_dtot;
    logic [4:0]      r1_dim;
    logic [17:0]     r1_doe;

    logic [NW-1:0]   r2_nsum;

    logic [17:0]     r3_doe;

    logic [6:0]      n_c1;
    logic [6:0]      r4_c1;
    logic [2:0]      r4_c2;
    logic            r4_c3;
    logic [17:0]     r4_doe;

    logic [17:0]     r5_yv;
    logic [17:0]     r5_doe;

    logic [8:0]      n_yoe;
    logic [8:0]      r6_yoe;
    logic [17:0]     r6_doe;

    logic [17:0]     r7_y365;
    logic [6:0]      r7_adj;
    logic [17:0]     r7_doe;

    logic [8:0]      r8_doy;

    logic [8:0]      n_start;
    logic [4:0]      n_dom;
    logic [4:0]      r9_day;

    logic [5:0]      n_keep;
    logic [2:0]      n_c2;
    logic [NW-1:0]   n_nsum;

    rtcat_cdiv #(.XW(18), .QW(7), .DIV(1460)) u_div_4y (
        .i_x (r3_doe),
        .o_q (n_c1)
    );

    rtcat_cdiv #(.XW(18), .QW(9), .DIV(365)) u_div_y (
        .i_x (r5_yv),
        .o_q (n_yoe)
    );

    always_comb begin
        n_keep = {(r1_dtot <= DT_W'(r1_dim)), r1_dtot[4:0]};
        n_nsum = NW'(r1_doe) + NW'(r1_dtot) - NW'(r1_dim) - NW'(1);
        n_c2   = 3'(r3_doe >= 18'd36524) + 3'(r3_doe >= 18'd73048) +
                 3'(r3_doe >= 18'd109572) + 3'(r3_doe >= 18'd146096);
        n_start = MONTH_START[0];
        for (int i = 1; i < 12; i++) begin
            if (r8_doy >= MONTH_START[i]) begin
                n_start = MONTH_START[i];
            end
        end
        n_dom = 5'(r8_doy - n_start + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_hms[0] <= i_hms;
        for (int i = 1; i < 9; i++) begin
            r_hms[i] <= r_hms[i-1];
        end
        r_keep[0] <= n_keep;
        for (int i = 1; i < 7; i++) begin
            r_keep[i] <= r_keep[i-1];
        end

        r1_dtot <= DT_W'(i_days) + DT_W'(i_day);
        r1_dim  <= i_dim;
        r1_doe  <= i_doe;

        r2_nsum <= n_nsum;

        r3_doe  <= (r2_nsum >= NW'(ERA_DAYS)) ? 18'(r2_nsum - NW'(ERA_DAYS))
                                               : 18'(r2_nsum);

        r4_c1   <= n_c1;
        r4_c2   <= n_c2;
        r4_c3   <= (r3_doe == 18'd146096);
        r4_doe  <= r3_doe;

        r5_yv   <= r4_doe - 18'(r4_c1) + 18'(r4_c2) - 18'(r4_c3);
        r5_doe  <= r4_doe;

        r6_yoe  <= n_yoe;
        r6_doe  <= r5_doe;

        r7_y365 <= 18'(r6_yoe) * 18'd365;
        r7_adj  <= year_adj(r6_yoe);
        r7_doe  <= r6_doe;

        r8_doy  <= 9'(r7_doe - r7_y365 - 18'(r7_adj));

        r9_day  <= r_keep[6][5] ? r_keep[6][4:0] : n_dom;

        o_day_bcd    <= 6'(bin_to_bcd(6'(r9_day)));
        o_hour_bcd   <= 6'(bin_to_bcd(6'(r_hms[8].hour)));
        o_minute_bcd <= 7'(bin_to_bcd(r_hms[8].minute));
        o_second_bcd <= 7'(bin_to_bcd(r_hms[8].second));
    end

    assign o_valid = r_vld[9];

endmodule

// ===== hw/rtl/rtc_alarm_time_adder_top.sv =====
// RTC alarm time adder, top level: BCD decode stage feeding the time, calendar
// and day-of-month pipelines. Uses rtcat_pkg, rtcat_time, rtcat_cal, rtcat_dom.
//
// Usage: present the current BCD date and time plus an interval in seconds
// and raise start for one cycle per word. busy is always low, so a new word
// is taken on every clock edge with start high.
// Each word gives one alarm word (day, hour, minute, second in BCD) on the
// o_alarm_* ports, marked by o_done for exactly one cycle. The path is 17
// register stages; o_done and the alarm word leave the last of them together.
// Throughput is one word per cycle; each divide by a constant is a reciprocal
// multiply or a few compares with a register after it, and the month/year
// wrap is done in closed form through the 400-year Gregorian era.
// The receiver cannot stall; results are never held back.
// Synchronous reset clears all valid bits; words in flight are dropped and
// payload registers keep whatever they held.
module rtc_alarm_time_adder_top #(
    parameter int INTERVAL_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [7:0]               i_century_bcd,
    input  logic [7:0]               i_year_bcd,
    input  logic [4:0]               i_month_bcd,
    input  logic [5:0]               i_day_bcd,
    input  logic [5:0]               i_hour_bcd,
    input  logic [6:0]               i_minute_bcd,
    input  logic [6:0]               i_second_bcd,
    input  logic [INTERVAL_BITS-1:0] i_interval_seconds,
    output logic                     o_done,
    output logic [5:0]               o_alarm_day_bcd,
    output logic [5:0]               o_alarm_hour_bcd,
    output logic [6:0]               o_alarm_minute_bcd,
    output logic [6:0]               o_alarm_second_bcd
);
    import rtcat_pkg::*;

    localparam int T1_W   = INTERVAL_BITS + 1;
    localparam int DAYS_W = days_w(INTERVAL_BITS);

    logic              r_vld;
    logic [T1_W-1:0]   r_t1;
    logic [6:0]        r_minute;
    logic [5:0]        r_hour;
    logic [5:0]        r_day;
    logic [4:0]        r_month;
    logic [7:0]        r_century;
    logic [7:0]        r_year;

    logic [6:0]        n_second;

    logic              tm_valid;
    logic [DAYS_W-1:0] tm_days;
    t_hms              tm_hms;

    logic [4:0]        cal_dim;
    logic [17:0]       cal_doe;
    logic [5:0]        cal_day;

    assign busy     = 1'b0;
    assign n_second = 7'(bcd_to_bin(8'(i_second_bcd)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1      <= T1_W'(n_second) + T1_W'(i_interval_seconds);
        r_minute  <= 7'(bcd_to_bin(8'(i_minute_bcd)));
        r_hour    <= 6'(bcd_to_bin(8'(i_hour_bcd)));
        r_day     <= 6'(bcd_to_bin(8'(i_day_bcd)));
        r_month   <= 5'(bcd_to_bin(8'(i_month_bcd)));
        r_century <= bcd_to_bin(i_century_bcd);
        r_year    <= bcd_to_bin(i_year_bcd);
    end

    rtcat_time #(.INTERVAL_BITS(INTERVAL_BITS)) u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld),
        .i_t1     (r_t1),
        .i_minute (r_minute),
        .i_hour   (r_hour),
        .o_valid  (tm_valid),
        .o_days   (tm_days),
        .o_hms    (tm_hms)
    );

    rtcat_cal u_cal (
        .i_clk     (i_clk),
        .i_century (r_century),
        .i_year    (r_year),
        .i_month   (r_month),
        .i_day     (r_day),
        .o_dim     (cal_dim),
        .o_doe     (cal_doe),
        .o_day     (cal_day)
    );

    rtcat_dom #(.DAYS_W(DAYS_W)) u_dom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (tm_valid),
        .i_days       (tm_days),
        .i_day        (cal_day),
        .i_dim        (cal_dim),
        .i_doe        (cal_doe),
        .i_hms        (tm_hms),
        .o_valid      (o_done),
        .o_day_bcd    (o_alarm_day_bcd),
        .o_hour_bcd   (o_alarm_hour_bcd),
        .o_minute_bcd (o_alarm_minute_bcd),
        .o_second_bcd (o_alarm_second_bcd)
    );

endmodule
